/* hw/rtl/sha1bh_pkg.sv */
// ----------------------------------------------------------------------------
// sha1bh_pkg
// Shared types, constants and codes of the SHA-1 byte stream hasher.
// ----------------------------------------------------------------------------
package sha1bh_pkg;

	localparam int unsigned NumChain  = 5;
	localparam int unsigned NumSched  = 16;
	localparam int unsigned CountW    = 61;
	localparam int unsigned PosW      = 6;
	localparam int unsigned RoundW    = 7;

	localparam logic [RoundW-1:0] LastRound    = 7'd79;
	localparam logic [RoundW-1:0] Round20      = 7'd20;
	localparam logic [RoundW-1:0] Round40      = 7'd40;
	localparam logic [RoundW-1:0] Round60      = 7'd60;
	localparam logic [PosW-1:0]   LastPos      = 6'd63;
	localparam logic [PosW-1:0]   LastMarkPos  = 6'd55;
	localparam logic [PosW-1:0]   LenPos       = 6'd56;
	localparam logic [2:0]        LastWordIdx  = 3'd4;
	localparam logic [7:0]        PadMark      = 8'h80;
	localparam logic [CountW-1:0] CountMax     = {CountW{1'b1}};

	localparam logic [31:0] InitChain [NumChain] = '{
		32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
	};

	localparam logic [31:0] K0 = 32'h5a827999;
	localparam logic [31:0] K1 = 32'h6ed9eba1;
	localparam logic [31:0] K2 = 32'h8f1bbcdc;
	localparam logic [31:0] K3 = 32'hca62c1d6;

	typedef struct packed {
		logic [7:0] message_byte;
		logic       has_byte;
		logic       end_of_message;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_item_t;

	typedef enum logic [1:0] {
		SEL_MSG,
		SEL_MARK,
		SEL_ZERO,
		SEL_LEN
	} byte_sel_t;

	typedef struct packed {
		logic              push;
		byte_sel_t         byte_sel;
		logic [PosW-1:0]   pos;
		logic              count_inc;
		logic              rnd_start;
		logic              rnd_step;
		logic [RoundW-1:0] round;
		logic              chain_add;
		logic              fin;
	} dp_cmd_t;

	typedef struct packed {
		logic out_busy;
	} dp_status_t;

	typedef enum logic [5:0] {
		ST_IDLE     = 6'b000001,
		ST_PAD_MARK = 6'b000010,
		ST_PAD_FILL = 6'b000100,
		ST_RND_INIT = 6'b001000,
		ST_RND      = 6'b010000,
		ST_ADD      = 6'b100000
	} ctrl_state_t;

endpackage

/* hw/rtl/sha1bh_ctrl.sv */
// ----------------------------------------------------------------------------
// sha1bh_ctrl
// Sequencer: byte intake, padding walk, round count and chain update.
// ----------------------------------------------------------------------------
module sha1bh_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   msg_valid,
	output logic                   msg_stall,
	input  sha1bh_pkg::msg_item_t  msg_item,
	input  sha1bh_pkg::dp_status_t status,
	output sha1bh_pkg::dp_cmd_t    cmd
);
	import sha1bh_pkg::*;

	ctrl_state_t       state_q, state_d;
	logic [PosW-1:0]   pos_q, pos_d;
	logic [RoundW-1:0] round_q, round_d;
	logic              eom_q, eom_d;
	logic              pad_q, pad_d;
	logic              last_blk_q, last_blk_d;
	logic              accept;

	assign msg_stall = (state_q != ST_IDLE);
	assign accept    = msg_valid && (state_q == ST_IDLE);

	always_comb begin
		state_d    = state_q;
		pos_d      = pos_q;
		round_d    = round_q;
		eom_d      = eom_q;
		pad_d      = pad_q;
		last_blk_d = last_blk_q;
		cmd        = '0;
		cmd.byte_sel = SEL_ZERO;
		cmd.pos      = pos_q;
		cmd.round    = round_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.byte_sel  = SEL_MSG;
				cmd.push      = accept && msg_item.has_byte;
				cmd.count_inc = accept && msg_item.has_byte;
				if (accept) begin
					if (msg_item.has_byte) begin
						pos_d = pos_q + 6'd1;
						if (pos_q == LastPos) begin
							eom_d   = msg_item.end_of_message;
							state_d = ST_RND_INIT;
						end else if (msg_item.end_of_message) begin
							state_d = ST_PAD_MARK;
						end
					end else if (msg_item.end_of_message) begin
						state_d = ST_PAD_MARK;
					end
				end
			end
			ST_PAD_MARK: begin
				cmd.push     = 1'b1;
				cmd.byte_sel = SEL_MARK;
				pad_d        = 1'b1;
				last_blk_d   = (pos_q <= LastMarkPos);
				pos_d        = pos_q + 6'd1;
				state_d      = (pos_q == LastPos) ? ST_RND_INIT : ST_PAD_FILL;
			end
			ST_PAD_FILL: begin
				cmd.push     = 1'b1;
				cmd.byte_sel = (last_blk_q && pos_q >= LenPos) ? SEL_LEN : SEL_ZERO;
				pos_d        = pos_q + 6'd1;
				if (pos_q == LastPos) begin
					state_d = ST_RND_INIT;
				end
			end
			ST_RND_INIT: begin
				cmd.rnd_start = 1'b1;
				round_d       = '0;
				state_d       = ST_RND;
			end
			ST_RND: begin
				cmd.rnd_step = 1'b1;
				if (round_q == LastRound) begin
					round_d = '0;
					state_d = ST_ADD;
				end else begin
					round_d = round_q + 7'd1;
				end
			end
			ST_ADD: begin
				if (pad_q && last_blk_q) begin
					// digest goes out through the output register; wait till it is free
					if (!status.out_busy) begin
						cmd.fin    = 1'b1;
						pad_d      = 1'b0;
						eom_d      = 1'b0;
						last_blk_d = 1'b0;
						state_d    = ST_IDLE;
					end
				end else if (pad_q) begin
					cmd.chain_add = 1'b1;
					last_blk_d    = 1'b1;
					state_d       = ST_PAD_FILL;
				end else begin
					cmd.chain_add = 1'b1;
					eom_d         = 1'b0;
					state_d       = eom_q ? ST_PAD_MARK : ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			pos_q      <= '0;
			round_q    <= '0;
			eom_q      <= 1'b0;
			pad_q      <= 1'b0;
			last_blk_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			pos_q      <= pos_d;
			round_q    <= round_d;
			eom_q      <= eom_d;
			pad_q      <= pad_d;
			last_blk_q <= last_blk_d;
		end
	end

	a_round_only_in_rnd: assert property (@(posedge clk) disable iff (!arst_n)
		(round_q != '0) |-> (state_q == ST_RND))
		else $error("round counter running outside the round state");

	a_rounds_end_in_add: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RND && round_q == LastRound) |=> (state_q == ST_ADD))
		else $error("compression did not end in chain update");

	a_fill_block_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RND_INIT) |-> (pos_q == '0))
		else $error("compression started on a partial block");

endmodule

/* hw/rtl/sha1bh_dp.sv */
// ----------------------------------------------------------------------------
// sha1bh_dp
// Datapath: byte packer, 16-word schedule window, round unit, chaining
// words, byte count and digest output register.
// ----------------------------------------------------------------------------
module sha1bh_dp (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sha1bh_pkg::dp_cmd_t    cmd,
	input  logic [7:0]             message_byte,
	output sha1bh_pkg::dp_status_t status,
	output logic                   dig_valid,
	input  logic                   dig_stall,
	output sha1bh_pkg::dig_item_t  dig_item
);
	import sha1bh_pkg::*;

	logic [23:0]       acc_q;
	logic [31:0]       w_q    [NumSched];
	logic [31:0]       ww_q   [NumChain];
	logic [31:0]       chain_q[NumChain];
	logic [31:0]       dig_q  [NumChain];
	logic [CountW-1:0] count_q;
	logic              out_valid_q;
	logic [2:0]        out_idx_q;

	logic [63:0] len_bits;
	logic [2:0]  len_idx;
	logic [7:0]  byte_val;
	logic        shift_en;
	logic [31:0] shift_in;
	logic [31:0] w_mix, w_new;
	logic [31:0] f_val, k_val, t_val;
	logic [31:0] a, b, c, d, e;

	assign len_bits = {count_q, 3'b000};
	assign len_idx  = ~cmd.pos[2:0];

	always_comb begin
		unique case (cmd.byte_sel)
			SEL_MSG:  byte_val = message_byte;
			SEL_MARK: byte_val = PadMark;
			SEL_ZERO: byte_val = 8'h00;
			SEL_LEN:  byte_val = len_bits[{len_idx, 3'b000} +: 8];
			default:  byte_val = 8'h00;
		endcase
	end

	// schedule: window holds W[t..t+15], W[t] at the bottom
	assign w_mix    = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign w_new    = {w_mix[30:0], w_mix[31]};
	assign shift_en = cmd.rnd_step || (cmd.push && cmd.pos[1:0] == 2'b11);
	assign shift_in = cmd.rnd_step ? w_new : {acc_q, byte_val};

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			acc_q <= {acc_q[15:0], byte_val};
		end
		if (shift_en) begin
			for (int i = 0; i < NumSched - 1; i++) begin
				w_q[i] <= w_q[i+1];
			end
			w_q[NumSched-1] <= shift_in;
		end
	end

	assign a = ww_q[0];
	assign b = ww_q[1];
	assign c = ww_q[2];
	assign d = ww_q[3];
	assign e = ww_q[4];

	always_comb begin
		priority if (cmd.round < Round20) begin
			f_val = (b & c) | (~b & d);
			k_val = K0;
		end else if (cmd.round < Round40) begin
			f_val = b ^ c ^ d;
			k_val = K1;
		end else if (cmd.round < Round60) begin
			f_val = (b & c) | (b & d) | (c & d);
			k_val = K2;
		end else begin
			f_val = b ^ c ^ d;
			k_val = K3;
		end
	end

	assign t_val = {a[26:0], a[31:27]} + f_val + e + k_val + w_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumChain; i++) begin
				ww_q[i] <= '0;
			end
		end else if (cmd.rnd_start) begin
			for (int i = 0; i < NumChain; i++) begin
				ww_q[i] <= chain_q[i];
			end
		end else if (cmd.rnd_step) begin
			ww_q[0] <= t_val;
			ww_q[1] <= a;
			ww_q[2] <= {b[1:0], b[31:2]};
			ww_q[3] <= c;
			ww_q[4] <= d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NumChain; i++) begin
				chain_q[i] <= InitChain[i];
			end
			count_q <= '0;
		end else begin
			if (cmd.fin) begin
				for (int i = 0; i < NumChain; i++) begin
					chain_q[i] <= InitChain[i];
				end
				count_q <= '0;
			end else if (cmd.chain_add) begin
				for (int i = 0; i < NumChain; i++) begin
					chain_q[i] <= chain_q[i] + ww_q[i];
				end
			end
			if (cmd.count_inc && count_q != CountMax) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			for (int i = 0; i < NumChain; i++) begin
				dig_q[i] <= chain_q[i] + ww_q[i];
			end
		end else if (out_valid_q && !dig_stall) begin
			for (int i = 0; i < NumChain - 1; i++) begin
				dig_q[i] <= dig_q[i+1];
			end
			dig_q[NumChain-1] <= dig_q[NumChain-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_idx_q   <= '0;
		end else if (cmd.fin) begin
			out_valid_q <= 1'b1;
			out_idx_q   <= '0;
		end else if (out_valid_q && !dig_stall) begin
			if (out_idx_q == LastWordIdx) begin
				out_valid_q <= 1'b0;
			end
			out_idx_q <= out_idx_q + 3'd1;
		end
	end

	assign dig_valid            = out_valid_q;
	assign dig_item.digest_word = dig_q[0];
	assign dig_item.word_index  = out_idx_q;
	assign dig_item.last_word   = (out_idx_q == LastWordIdx);
	assign status.out_busy      = out_valid_q;

	a_fin_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin |-> !out_valid_q)
		else $error("digest loaded over a digest still going out");

	a_out_ends_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid_q) |-> $past(!dig_stall && out_idx_q == LastWordIdx))
		else $error("digest output stopped before its last word");

	a_no_push_in_rounds: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rnd_step |-> !cmd.push)
		else $error("byte pushed into schedule window during rounds");

endmodule

/* hw/rtl/sha1_byte_stream_hasher_unit.sv */
// ----------------------------------------------------------------------------
// sha1_byte_stream_hasher_unit - SHA-1 over a byte stream, five-beat digest.
// Throughput: one byte beat per cycle while a block fills; each full 64-byte
//   block then holds msg_stall through the load, 80 rounds on one round
//   unit and the chain add.
// Digest: the end beat is followed by padding (one byte a cycle to the
//   block end) and one or two compressions, plus any wait for the previous
//   digest to drain.
// Reset: chaining words to the SHA-1 IV, count zero, sequencer idle, no digest.
// ----------------------------------------------------------------------------
module sha1_byte_stream_hasher_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  msg_valid,
	output logic                  msg_stall,
	input  sha1bh_pkg::msg_item_t msg_item,
	output logic                  dig_valid,
	input  logic                  dig_stall,
	output sha1bh_pkg::dig_item_t dig_item
);
	import sha1bh_pkg::*;

	// Controller and datapath talk only through cmd and status.
	// Byte beats are taken only while the sequencer is idle; padding then
	// walks the rest of the block one byte per cycle, writing 0x80, zeros
	// and, in the final block, the big-endian bit length.
	// The digest sits in its own five-word output register, so the next
	// message may stream in while the previous digest drains.
	dp_cmd_t    cmd;
	dp_status_t status;

	sha1bh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg_item  (msg_item),
		.status    (status),
		.cmd       (cmd)
	);

	sha1bh_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.message_byte (msg_item.message_byte),
		.status       (status),
		.dig_valid    (dig_valid),
		.dig_stall    (dig_stall),
		.dig_item     (dig_item)
	);

	a_out_ready_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_valid && dig_item.last_word) |-> (dig_item.word_index == LastWordIdx))
		else $error("last word flag on wrong digest word");

	a_stall_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.rnd_step || cmd.rnd_start) |-> msg_stall)
		else $error("byte beats accepted during compression");

	a_word_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_valid && dig_stall) |=> (dig_valid && $stable(dig_item)))
		else $error("stalled digest beat changed");

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb - SHA-1 byte stream hasher testbench
// Feeds messages one byte beat at a time, hashes every accepted beat in a
// behavioural SHA-1 and compares each digest beat against it. Runs a
// directed set, then random messages under four handshake pressure phases.
// ----------------------------------------------------------------------------
module tb;
	import sha1bh_pkg::*;

	// ------------------------------------------------------------------
	// Clock and reset
	// ------------------------------------------------------------------
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// DUT ports, all driven to known values from time zero
	// ------------------------------------------------------------------
	logic      msg_valid = 1'b0;
	logic      msg_stall;
	msg_item_t msg_item  = '0;
	logic      dig_valid;
	logic      dig_stall = 1'b0;
	dig_item_t dig_item;

	sha1_byte_stream_hasher_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.msg_valid (msg_valid),
		.msg_stall (msg_stall),
		.msg_item  (msg_item),
		.dig_valid (dig_valid),
		.dig_stall (dig_stall),
		.dig_item  (dig_item)
	);

	// ------------------------------------------------------------------
	// Shared testbench state
	// ------------------------------------------------------------------
	msg_item_t msg_beats_q[$];      // beats waiting to be driven
	dig_item_t digest_expect_q[$];  // digest beats predicted, not yet seen
	int        send_idle_pct  = 0;  // chance per cycle the sender holds off
	int        recv_stall_pct = 0;  // chance per cycle the receiver stalls
	int        fault_count    = 0;

	// ------------------------------------------------------------------
	// Behavioural SHA-1: chaining words, block buffer, byte count, fill
	// ------------------------------------------------------------------
	logic [31:0]       hash_chain [NumChain];
	logic [31:0]       blk_words  [NumSched];
	logic [CountW-1:0] byte_total;
	logic [PosW-1:0]   blk_fill;

	function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned s);
		return (v << s) | (v >> (32 - s));
	endfunction

	// Big-endian byte placement; first byte of a word clears it.
	task automatic blk_put(input logic [PosW-1:0] pos, input logic [7:0] b);
		if (pos[1:0] == 2'd0)
			blk_words[pos[5:2]] = 32'd0;
		blk_words[pos[5:2]] |= 32'(b) << (24 - 8 * int'(pos[1:0]));
	endtask

	task automatic sha1_compress();
		logic [31:0] w [80];
		logic [31:0] a, b, c, d, e, f, k, t;
		int          r;
		for (r = 0; r < 16; r++)
			w[r] = blk_words[r];
		for (r = 16; r < 80; r++)
			w[r] = rotl(w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16], 1);
		a = hash_chain[0];
		b = hash_chain[1];
		c = hash_chain[2];
		d = hash_chain[3];
		e = hash_chain[4];
		for (r = 0; r < 80; r++) begin
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = K0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K2;
			end else begin
				f = b ^ c ^ d;
				k = K3;
			end
			t = rotl(a, 5) + f + e + k + w[r];
			e = d;
			d = c;
			c = rotl(b, 30);
			b = a;
			a = t;
		end
		hash_chain[0] += a;
		hash_chain[1] += b;
		hash_chain[2] += c;
		hash_chain[3] += d;
		hash_chain[4] += e;
	endtask

	// One accepted message beat; an end beat queues the five digest words.
	task automatic sha1_absorb_beat(input msg_item_t it);
		logic [63:0] bit_len;
		int          p;
		int          i;
		if (it.has_byte) begin
			blk_put(blk_fill, it.message_byte);
			blk_fill = blk_fill + 1'b1;
			if (byte_total != CountMax)
				byte_total = byte_total + 1'b1;
			if (blk_fill == '0)
				sha1_compress();
		end
		if (it.end_of_message) begin
			bit_len = {byte_total, 3'b000};
			p = int'(blk_fill);
			blk_put(PosW'(p), PadMark);
			p++;
			// no room for the length: close this block, length goes in another
			if (p > int'(LenPos)) begin
				while (p < 64) begin
					blk_put(PosW'(p), 8'h00);
					p++;
				end
				sha1_compress();
				p = 0;
			end
			while (p < int'(LenPos)) begin
				blk_put(PosW'(p), 8'h00);
				p++;
			end
			blk_words[14] = bit_len[63:32];
			blk_words[15] = bit_len[31:0];
			sha1_compress();
			for (i = 0; i < NumChain; i++)
				digest_expect_q.push_back('{
					digest_word: hash_chain[i],
					word_index:  3'(i),
					last_word:   (3'(i) == LastWordIdx)
				});
			hash_chain = InitChain;
			byte_total = '0;
			blk_fill   = '0;
		end
	endtask

	// ------------------------------------------------------------------
	// Driver: pops the next beat when the line is free, holds it while
	// stalled, and hashes each beat at the edge that accepts it.
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msg_valid <= 1'b0;
			msg_item  <= '0;
		end else begin
			if (msg_valid && !msg_stall)
				sha1_absorb_beat(msg_item);
			if (!msg_valid || !msg_stall) begin
				if (msg_beats_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					msg_valid <= 1'b1;
					msg_item  <= msg_beats_q.pop_front();
				end else begin
					msg_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: checks each accepted digest beat against the oldest
	// prediction, then picks the stall for the next cycle.
	// ------------------------------------------------------------------
	dig_item_t digest_want;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dig_stall <= 1'b0;
		end else begin
			if (dig_valid && !dig_stall) begin
				if (digest_expect_q.size() == 0) begin
					$display("%0t unexpected digest beat: word %h index %0d last %b",
						$time, dig_item.digest_word, dig_item.word_index, dig_item.last_word);
					fault_count++;
				end else begin
					digest_want = digest_expect_q.pop_front();
					if (dig_item.digest_word !== digest_want.digest_word ||
					    dig_item.word_index !== digest_want.word_index ||
					    dig_item.last_word !== digest_want.last_word) begin
						$display("%0t digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
							$time, digest_want.digest_word, digest_want.word_index,
							digest_want.last_word, dig_item.digest_word,
							dig_item.word_index, dig_item.last_word);
						fault_count++;
					end
				end
			end
			dig_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic push_beat(input logic [7:0] b, input logic has, input logic eom);
		msg_beats_q.push_back('{message_byte: b, has_byte: has, end_of_message: eom});
	endtask

	// Random-content message of len bytes. The end either rides on the
	// last byte or follows as a byte-less end beat. Ignored beats with junk
	// bytes are sprinkled in and not counted.
	task automatic queue_message(input int len, input bit split_end, inout int items);
		int n;
		for (n = 0; n < len; n++) begin
			if ($urandom_range(99) < 8)
				push_beat(8'($urandom), 1'b0, 1'b0);
			push_beat(8'($urandom), 1'b1, (n == len - 1) && !split_end);
			items++;
		end
		if (split_end || len == 0) begin
			push_beat(8'($urandom), 1'b0, 1'b1);
			items++;
		end
	endtask

	// Sampled at the falling edge so every clocked update has settled.
	task automatic wait_drained();
		do
			@(negedge clk);
		while (msg_beats_q.size() != 0 || msg_valid || digest_expect_q.size() != 0);
	endtask

	task automatic run_phase(input int idle_pct, input int stall_pct);
		int items, len, sel;
		items = 0;
		@(negedge clk);
		send_idle_pct  = idle_pct;
		recv_stall_pct = stall_pct;
		// mostly short messages, a good share straddling one block boundary
		while (items < 30) begin
			sel = $urandom_range(99);
			if (sel < 50)
				len = $urandom_range(12);
			else if (sel < 85)
				len = $urandom_range(70, 50);
			else
				len = $urandom_range(130, 100);
			queue_message(len, (len == 0) || ($urandom_range(1) == 1), items);
		end
		wait_drained();
	endtask

	// ------------------------------------------------------------------
	// Sequence: reset, directed beats, boundary lengths, pressure phases
	// ------------------------------------------------------------------
	initial begin
		int boundary_items;
		boundary_items = 0;
		hash_chain = InitChain;
		byte_total = '0;
		blk_fill   = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// ignored beat, then the empty message
		push_beat(8'hff, 1'b0, 1'b0);
		push_beat(8'h5a, 1'b0, 1'b1);
		// one-byte messages at both byte extremes
		push_beat(8'h00, 1'b1, 1'b1);
		push_beat(8'hff, 1'b1, 1'b1);
		// "abc", end on the last byte
		push_beat(8'h61, 1'b1, 1'b0);
		push_beat(8'h62, 1'b1, 1'b0);
		push_beat(8'h63, 1'b1, 1'b1);
		// bytes with an ignored beat inside, closed by a byte-less end
		push_beat(8'h01, 1'b1, 1'b0);
		push_beat(8'h3c, 1'b0, 1'b0);
		push_beat(8'h80, 1'b1, 1'b0);
		push_beat(8'h7f, 1'b1, 1'b0);
		push_beat(8'ha5, 1'b0, 1'b1);
		wait_drained();

		// padding just fits, just overflows, end on the last byte of a block
		queue_message(55, 1'b0, boundary_items);
		queue_message(56, 1'b0, boundary_items);
		queue_message(64, 1'b0, boundary_items);
		wait_drained();

		run_phase(0, 0);
		run_phase(61, 0);
		run_phase(0, 61);
		run_phase(15, 15);

		// catch any stray digest beats after the last message
		repeat (300) @(negedge clk);
		if (fault_count == 0 && digest_expect_q.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest legal run.
	initial begin
		#5000000;
		$display("status: fail");
		$finish;
	end

endmodule

/* filelist.f */
hw/rtl/sha1bh_pkg.sv
hw/rtl/sha1bh_ctrl.sv
hw/rtl/sha1bh_dp.sv
hw/rtl/sha1_byte_stream_hasher_unit.sv
tb/tb.sv
